// File: rtl/iwcu_pkg.sv
// Package for the Wolff cluster update block: sequencer state type, mode codes
// and the xorshift step. No dependencies.
package iwcu_pkg;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_READ    = 2'd1,
      MODE_CLUSTER = 2'd2,
      MODE_MEASURE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LATTICE_SIZE = 3'd0,
      CSR_THRESHOLD    = 3'd1,
      CSR_RNG_SEED     = 3'd2
   } csr_type;

   typedef enum logic [15:0] {
      ST_CLEAR    = 16'h0001,
      ST_IDLE     = 16'h0002,
      ST_REDUCE   = 16'h0004,
      ST_RD_WAIT  = 16'h0008,
      ST_SEED_WR  = 16'h0010,
      ST_POP      = 16'h0020,
      ST_POP_WAIT = 16'h0040,
      ST_CUR_WAIT = 16'h0080,
      ST_NB_RD    = 16'h0100,
      ST_NB_DEC   = 16'h0200,
      ST_SW_RD    = 16'h0400,
      ST_SW_WR    = 16'h0800,
      ST_MS_SITE  = 16'h1000,
      ST_MS_STEP  = 16'h2000,
      ST_DONE     = 16'h4000
   } state_type;

   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

// File: rtl/ising_wolff_cluster_update.sv
// Two-dimensional Ising lattice with Wolff cluster update, spin access and measurement.
// Uses iwcu_pkg.
//
// After reset the block clears all 2**(2*clog2(MAX_SIDE)) words (4096 at the default) of
// the lattice memory before it takes the first item. One item is in work at a time, and
// every access goes through the lattice memory, which has one write port and one port with a
// registered read. A spin write or read first reduces its coordinates modulo the side by
// repeated subtraction. A cluster update pops each cluster site from the queue, reads it and
// tries its four neighbours, then sweeps all active sites to flip the cluster. A measurement
// reads every active site and its four neighbours.
module ising_wolff_cluster_update
   import iwcu_pkg::*;
#(
   parameter int MAX_SIDE       = 64,
   parameter int THRESHOLD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], row[7:2], col[13:8], write_spin[14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_spin[0], cluster_size[13:1],
                                    // magnetisation_sum[27:14], energy_times_two[43:28]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int RW    = (SW > 6) ? SW : 6;
   localparam int LW    = (SW > 7) ? SW : 7;
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int SITES = MAX_SIDE * MAX_SIDE;
   localparam int FAW   = $clog2(SITES);
   localparam int HW    = $clog2(SITES + 1);
   localparam int MW    = HW + 1;
   localparam int EW    = HW + 3;
   localparam int CMPW  = (THRESHOLD_BITS > 17) ? THRESHOLD_BITS : 17;

   logic [1:0] lat_mem [DEPTH];
   logic [AW-1:0] fifo_mem [SITES];

   state_type state_ff, state_in;
   logic [6:0]    lsize_ff, lsize_in;
   logic [16:0]   thr_ff, thr_in;
   logic [31:0]   rng_ff, rng_in;
   logic [SW-1:0] side_ff, side_in;
   mode_type      mode_ff, mode_in;
   logic          ws_ff, ws_in;
   logic [RW-1:0] red_r_ff, red_r_in, red_c_ff, red_c_in;
   logic [CW-1:0] cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic          sp_ff, sp_in;
   logic [2:0]    k_ff, k_in;
   logic [AW-1:0] nb_ff, nb_in;
   logic [HW-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic signed [MW-1:0] mag_ff, mag_in;
   logic signed [EW-1:0] ene_ff, ene_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_data_ff, rsp_data_in;
   logic [47:0]   res_ff, res_in;

   logic          lat_we;
   logic [AW-1:0] lat_wa, lat_ra;
   logic [1:0]    lat_wd, lat_q;
   logic          fifo_we;
   logic [AW-1:0] fifo_wd, fifo_q;

   logic [LW-1:0]             lsize_ext;
   logic [CW-1:0]             red_r_c, red_c_c;
   logic [THRESHOLD_BITS-1:0] draw;
   logic                      join_ok, last_col, last_row;
   logic [AW-1:0]             cur_nb;

   function automatic logic [AW-1:0] nb_addr(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                             input logic [SW-1:0] s, input logic [1:0] k);
      logic [SW-1:0] r1, c1, sm1;
      logic [CW-1:0] rp, rm, cp, cm;
      logic [AW-1:0] a;
      sm1 = s - 1'b1;
      r1  = SW'(r) + 1'b1;
      c1  = SW'(c) + 1'b1;
      rp  = (r1 == s) ? '0 : r1[CW-1:0];
      cp  = (c1 == s) ? '0 : c1[CW-1:0];
      rm  = (r == '0) ? sm1[CW-1:0] : r - 1'b1;
      cm  = (c == '0) ? sm1[CW-1:0] : c - 1'b1;
      case (k)
         2'd0:    a = {rp, c};
         2'd1:    a = {rm, c};
         2'd2:    a = {r, cp};
         default: a = {r, cm};
      endcase
      return a;
   endfunction

   assign lsize_ext  = LW'(lsize_ff);
   assign red_r_c    = red_r_ff[CW-1:0];
   assign red_c_c    = red_c_ff[CW-1:0];
   assign draw       = rng_ff[31 -: THRESHOLD_BITS];
   assign cur_nb     = nb_addr(cur_r_ff, cur_c_ff, side_ff, k_ff[1:0]);
   assign join_ok    = (lat_q[0] == sp_ff) && !lat_q[1] &&
                       (CMPW'(draw) < CMPW'(thr_ff)) && (tail_ff < HW'(SITES));
   assign last_col   = (SW'(cur_c_ff) == side_ff - 1'b1);
   assign last_row   = (SW'(cur_r_ff) == side_ff - 1'b1);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      lsize_in     = lsize_ff;
      thr_in       = thr_ff;
      rng_in       = rng_ff;
      side_in      = side_ff;
      mode_in      = mode_ff;
      ws_in        = ws_ff;
      red_r_in     = red_r_ff;
      red_c_in     = red_c_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      sp_in        = sp_ff;
      k_in         = k_ff;
      nb_in        = nb_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      ene_in       = ene_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      lat_we       = 1'b0;
      lat_wa       = {cur_r_ff, cur_c_ff};
      lat_wd       = 2'b00;
      lat_ra       = {cur_r_ff, cur_c_ff};
      fifo_we      = 1'b0;
      fifo_wd      = nb_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            lat_we = 1'b1;
            lat_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = mode_type'(req_tdata[1:0]);
               red_r_in = RW'(req_tdata[7:2]);
               red_c_in = RW'(req_tdata[13:8]);
               ws_in    = req_tdata[14];
               if (lsize_ext < LW'(2)) begin
                  side_in = SW'(2);
               end else if (lsize_ext > LW'(MAX_SIDE)) begin
                  side_in = SW'(MAX_SIDE);
               end else begin
                  side_in = lsize_ext[SW-1:0];
               end
               head_in  = '0;
               tail_in  = '0;
               res_in   = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (red_r_ff >= RW'(side_ff)) begin
               red_r_in = red_r_ff - RW'(side_ff);
            end
            if (red_c_ff >= RW'(side_ff)) begin
               red_c_in = red_c_ff - RW'(side_ff);
            end
            if (red_r_ff < RW'(side_ff) && red_c_ff < RW'(side_ff)) begin
               cur_r_in = red_r_c;
               cur_c_in = red_c_c;
               lat_ra   = {red_r_c, red_c_c};
               case (mode_ff)
                  MODE_WRITE: begin
                     lat_we   = 1'b1;
                     lat_wa   = {red_r_c, red_c_c};
                     lat_wd   = {1'b0, ws_ff};
                     state_in = ST_DONE;
                  end
                  MODE_READ:    state_in = ST_RD_WAIT;
                  MODE_CLUSTER: state_in = ST_SEED_WR;
                  default: begin
                     cur_r_in = '0;
                     cur_c_in = '0;
                     mag_in   = '0;
                     ene_in   = '0;
                     state_in = ST_MS_SITE;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_in[0] = lat_q[0];
            state_in  = ST_DONE;
         end
         ST_SEED_WR: begin
            lat_we   = 1'b1;
            lat_wd   = {1'b1, lat_q[0]};
            fifo_we  = 1'b1;
            fifo_wd  = {cur_r_ff, cur_c_ff};
            nb_in    = {cur_r_ff, cur_c_ff};
            head_in  = '0;
            tail_in  = HW'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_ff != tail_ff && head_ff < HW'(SITES)) begin
               state_in = ST_POP_WAIT;
            end else begin
               cur_r_in = '0;
               cur_c_in = '0;
               cnt_in   = '0;
               state_in = ST_SW_RD;
            end
         end
         ST_POP_WAIT: begin
            cur_r_in = fifo_q[AW-1:CW];
            cur_c_in = fifo_q[CW-1:0];
            lat_ra   = fifo_q;
            head_in  = head_ff + 1'b1;
            state_in = ST_CUR_WAIT;
         end
         ST_CUR_WAIT: begin
            sp_in    = lat_q[0];
            k_in     = '0;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            lat_ra   = cur_nb;
            nb_in    = cur_nb;
            rng_in   = xorshift(rng_ff);
            state_in = ST_NB_DEC;
         end
         ST_NB_DEC: begin
            if (join_ok) begin
               lat_we  = 1'b1;
               lat_wa  = nb_ff;
               lat_wd  = {1'b1, sp_ff};
               fifo_we = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            k_in     = k_ff + 1'b1;
            state_in = (k_ff == 3'd3) ? ST_POP : ST_NB_RD;
         end
         ST_SW_RD: begin
            state_in = ST_SW_WR;
         end
         ST_SW_WR: begin
            if (lat_q[1]) begin
               lat_we = 1'b1;
               lat_wd = {1'b0, ~lat_q[0]};
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = ST_SW_RD;
            if (last_col) begin
               cur_c_in = '0;
               cur_r_in = cur_r_ff + 1'b1;
               if (last_row) begin
                  res_in[13:1] = 13'(cnt_in);
                  state_in     = ST_DONE;
               end
            end else begin
               cur_c_in = cur_c_ff + 1'b1;
            end
         end
         ST_MS_SITE: begin
            k_in     = '0;
            state_in = ST_MS_STEP;
         end
         ST_MS_STEP: begin
            if (k_ff == 3'd0) begin
               sp_in  = lat_q[0];
               mag_in = lat_q[0] ? mag_ff - 1'b1 : mag_ff + 1'b1;
            end else begin
               ene_in = (lat_q[0] == sp_ff) ? ene_ff - 1'b1 : ene_ff + 1'b1;
            end
            if (k_ff != 3'd4) begin
               lat_ra = cur_nb;
               k_in   = k_ff + 1'b1;
            end else begin
               state_in = ST_MS_SITE;
               if (last_col) begin
                  cur_c_in = '0;
                  cur_r_in = cur_r_ff + 1'b1;
                  if (last_row) begin
                     res_in[27:14] = 14'(mag_ff);
                     res_in[43:28] = 16'(ene_in);
                     state_in      = ST_DONE;
                  end
               end else begin
                  cur_c_in = cur_c_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case ({1'b0, csr_index})
            CSR_LATTICE_SIZE: lsize_in = csr_wdata[6:0];
            CSR_THRESHOLD:    thr_in   = csr_wdata[16:0];
            CSR_RNG_SEED:     rng_in   = (csr_wdata == '0) ? 32'd1 : csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (lat_we) begin
         lat_mem[lat_wa] <= lat_wd;
      end
      lat_q <= lat_mem[lat_ra];
      if (fifo_we) begin
         fifo_mem[tail_ff[FAW-1:0]] <= fifo_wd;
      end
      fifo_q <= fifo_mem[head_ff[FAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         lsize_ff     <= 7'd64;
         thr_ff       <= '0;
         rng_ff       <= 32'd1;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lsize_ff     <= lsize_in;
         thr_ff       <= thr_in;
         rng_ff       <= rng_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      mode_ff     <= mode_in;
      ws_ff       <= ws_in;
      red_r_ff    <= red_r_in;
      red_c_ff    <= red_c_in;
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      sp_ff       <= sp_in;
      k_ff        <= k_in;
      nb_ff       <= nb_in;
      cnt_ff      <= cnt_in;
      mag_ff      <= mag_in;
      ene_ff      <= ene_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/iwcu_checker.sv
// Port-level checks for ising_wolff_cluster_update, bound to the top level.
// No package dependencies.
module iwcu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous item in work");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_one_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && (rsp_tdata[13:1] != 13'd0)))
      else $error("result mixes read spin and cluster size");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity straight after reset");

endmodule

bind ising_wolff_cluster_update iwcu_checker u_iwcu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
